@@ hw/rtl/stbc_pkg.sv @@
// Shared types, constants and control program of the sensor trend beacon classifier.
`default_nettype none

package stbc_pkg;

  localparam int HistoryDepth = 16;
  localparam int IdxW         = $clog2(HistoryDepth);
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;
  localparam int StepW        = 3;

  typedef logic [2:0] msg_type_t;
  localparam msg_type_t TYPE_PERIODIC  = 3'd0;
  localparam msg_type_t TYPE_GAIN      = 3'd1;
  localparam msg_type_t TYPE_LOW_LEVEL = 3'd2;
  localparam msg_type_t TYPE_LOSE      = 3'd3;
  localparam msg_type_t TYPE_LOW_BATT  = 3'd4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LOW_LEVEL = 2'd0;
  localparam cfg_idx_t CFG_BATT_LOW  = 2'd1;
  localparam cfg_idx_t CFG_GAP       = 2'd2;

  localparam logic OP_MEASURE   = 1'b0;
  localparam logic OP_ADVERTISE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  sample_x;
    logic [7:0]  sample_y;
    logic        read_ok;
    logic [15:0] battery_level;
  } stbc_in_t;

  typedef struct packed {
    msg_type_t   message_type;
    logic [7:0]  level_x;
    logic [7:0]  level_y;
    logic [7:0]  good_reads;
    logic [15:0] battery_out;
    logic [7:0]  window_max;
    logic [7:0]  window_min;
  } stbc_out_t;

  typedef logic [StepW-1:0] step_t;
  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_WRITE    = 3'd1;
  localparam step_t ST_SCAN     = 3'd2;
  localparam step_t ST_DRAIN    = 3'd3;
  localparam step_t ST_CLASSIFY = 3'd4;
  localparam step_t ST_EMIT     = 3'd5;
  localparam step_t ST_ADV      = 3'd6;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_WAIT_IN,
    JMP_SCAN,
    JMP_WAIT_OUT
  } jump_e;

  typedef struct packed {
    logic  in_ready;
    logic  hist_write;
    logic  scan_rd;
    logic  classify;
    logic  advertise;
    logic  emit;
    jump_e jump;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic adv;
    logic scan_last;
    logic out_free;
  } status_t;

  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '0;
    unique case (s)
      ST_IDLE: begin
        c.in_ready = 1'b1;
        c.jump     = JMP_WAIT_IN;
        c.target   = ST_ADV;
      end
      ST_WRITE: begin
        c.hist_write = 1'b1;
        c.jump       = JMP_NEXT;
      end
      ST_SCAN: begin
        c.scan_rd = 1'b1;
        c.jump    = JMP_SCAN;
      end
      ST_DRAIN: begin
        c.jump = JMP_NEXT;
      end
      ST_CLASSIFY: begin
        c.classify = 1'b1;
        c.jump     = JMP_NEXT;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.jump   = JMP_WAIT_OUT;
        c.target = ST_IDLE;
      end
      ST_ADV: begin
        c.advertise = 1'b1;
        c.jump      = JMP_GOTO;
        c.target    = ST_EMIT;
      end
      default: begin
        c.jump   = JMP_GOTO;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stbc_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module stbc_seq (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  stbc_pkg::status_t st_i,
  output stbc_pkg::ctl_t  ctl_o
);

  stbc_pkg::step_t step_q;
  stbc_pkg::step_t step_d;
  stbc_pkg::ctl_t  ctl;

  assign ctl   = stbc_pkg::ucode(step_q);
  assign ctl_o = ctl;

  always_comb begin
    step_d = step_q;
    unique case (ctl.jump)
      stbc_pkg::JMP_NEXT:  step_d = step_q + 3'd1;
      stbc_pkg::JMP_GOTO:  step_d = ctl.target;
      stbc_pkg::JMP_WAIT_IN: begin
        if (st_i.accept) begin
          step_d = st_i.adv ? ctl.target : step_q + 3'd1;
        end
      end
      stbc_pkg::JMP_SCAN: begin
        if (st_i.scan_last) begin
          step_d = step_q + 3'd1;
        end
      end
      stbc_pkg::JMP_WAIT_OUT: begin
        if (st_i.out_free) begin
          step_d = ctl.target;
        end
      end
      default: step_d = stbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= stbc_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stbc_dp.sv @@
// Datapath: input latch, config registers, history memory, scan, classify, output register.
`default_nettype none

module stbc_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  stbc_pkg::ctl_t                   ctl_i,
  output stbc_pkg::status_t                st_o,
  input  wire                              in_valid_i,
  input  stbc_pkg::stbc_in_t               in_i,
  output stbc_pkg::stbc_out_t              out_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  input  wire                              cfg_we_i,
  input  wire [stbc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [stbc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int IdxW = stbc_pkg::IdxW;
  localparam int Depth = stbc_pkg::HistoryDepth;

  logic [7:0]  low_thr_q;
  logic [15:0] batt_thr_q;
  logic [7:0]  gap_thr_q;

  stbc_pkg::stbc_in_t in_q;
  logic               accept;

  logic [7:0]       hist_mem [Depth];
  logic [Depth-1:0] hist_vld_q;
  logic [IdxW-1:0]  slot_q;
  logic [IdxW-1:0]  idx_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic             dv_q;
  logic [IdxW-1:0]  di_q;
  logic [7:0]       v;

  logic [7:0]  hi_q, lo_q, prev_q;
  logic [IdxW-1:0] rises_q, falls_q;
  logic [7:0]  gap;

  stbc_pkg::msg_type_t type_q;
  logic [7:0]  stored_x_q, stored_y_q, count_q, max_q, min_q;

  stbc_pkg::stbc_out_t out_q;
  logic                out_valid_q;
  logic                out_free;
  logic                load;

  assign accept   = in_valid_i && ctl_i.in_ready;
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = ctl_i.emit && out_free;
  assign v        = rd_vld_q ? rd_data_q : 8'd0;
  assign gap      = hi_q - lo_q;

  assign st_o.accept    = accept;
  assign st_o.adv       = in_i.operation == stbc_pkg::OP_ADVERTISE;
  assign st_o.scan_last = idx_q == IdxW'(Depth - 1);
  assign st_o.out_free  = out_free;

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= 8'd16;
      batt_thr_q <= 16'd2200;
      gap_thr_q  <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stbc_pkg::CFG_LOW_LEVEL: low_thr_q  <= cfg_data_i[7:0];
        stbc_pkg::CFG_BATT_LOW:  batt_thr_q <= cfg_data_i;
        stbc_pkg::CFG_GAP:       gap_thr_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    if (ctl_i.hist_write) begin
      hist_mem[slot_q] <= in_q.sample_x;
    end
    rd_data_q <= hist_mem[idx_q];
    rd_vld_q  <= hist_vld_q[idx_q];
    di_q      <= idx_q;
    if (load) begin
      out_q.message_type <= type_q;
      out_q.level_x      <= stored_x_q;
      out_q.level_y      <= stored_y_q;
      out_q.good_reads   <= count_q;
      out_q.battery_out  <= (in_q.operation == stbc_pkg::OP_ADVERTISE) ?
                            in_q.battery_level : 16'd0;
      out_q.window_max   <= max_q;
      out_q.window_min   <= min_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q  <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
      prev_q      <= '0;
      rises_q     <= '0;
      falls_q     <= '0;
      type_q      <= stbc_pkg::TYPE_PERIODIC;
      stored_x_q  <= '0;
      stored_y_q  <= '0;
      count_q     <= '0;
      max_q       <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dv_q <= ctl_i.scan_rd;

      if (ctl_i.hist_write) begin
        hist_vld_q[slot_q] <= 1'b1;
        slot_q     <= (slot_q == IdxW'(Depth - 1)) ? '0 : slot_q + IdxW'(1);
        stored_x_q <= in_q.sample_x;
        stored_y_q <= in_q.sample_y;
        if (in_q.read_ok) begin
          count_q <= count_q + 8'd1;
        end
        idx_q <= '0;
      end else if (ctl_i.scan_rd) begin
        idx_q <= idx_q + IdxW'(1);
      end

      if (dv_q) begin
        prev_q <= v;
        if (di_q == '0) begin
          hi_q    <= v;
          lo_q    <= v;
          rises_q <= '0;
          falls_q <= '0;
        end else begin
          if (v > hi_q) hi_q <= v;
          if (v < lo_q) lo_q <= v;
          if (di_q > IdxW'(1)) begin
            if (v > prev_q) begin
              rises_q <= rises_q + IdxW'(1);
            end else if (v < prev_q) begin
              falls_q <= falls_q + IdxW'(1);
            end
          end
        end
      end

      if (ctl_i.classify) begin
        max_q <= hi_q;
        min_q <= lo_q;
        if (gap > gap_thr_q && rises_q > falls_q) begin
          type_q <= stbc_pkg::TYPE_GAIN;
        end else if (gap > gap_thr_q && falls_q > rises_q) begin
          type_q <= stbc_pkg::TYPE_LOSE;
        end else begin
          type_q <= stbc_pkg::TYPE_PERIODIC;
        end
      end

      if (ctl_i.advertise) begin
        if (stored_x_q < low_thr_q) begin
          type_q <= stbc_pkg::TYPE_LOW_LEVEL;
        end else if (in_q.battery_level <= batt_thr_q) begin
          type_q <= stbc_pkg::TYPE_LOW_BATT;
        end
      end

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sensor_trend_beacon_classifier.sv @@
// Top level of the sensor trend beacon classifier: sequencer, datapath and checks.
`default_nettype none

// Each input beat yields exactly one result beat. A measurement beat stores X and Y,
// counts a good read, writes X into the 16-entry history and then scans the history
// one entry per cycle through its single read port, then drains, classifies and
// loads its result; an advertise beat runs its advertise step and then loads its
// result. The next beat is accepted only after the result is loaded, and a full
// output register stalls that load. Results sit in an output register, so the
// next beat is accepted while a result still waits; a new result is held back
// only while that register is full. Configuration writes take effect at once and
// are meant for idle periods. History entries read as zero until written.
module sensor_trend_beacon_classifier (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  stbc_pkg::stbc_in_t            in_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output stbc_pkg::stbc_out_t           out_o,
  input  wire                           cfg_we_i,
  input  wire [stbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [stbc_pkg::CfgDataW-1:0]  cfg_data_i
);

  stbc_pkg::ctl_t    ctl;
  stbc_pkg::status_t st;

  assign in_ready_o = ctl.in_ready;

  stbc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .ctl_o  (ctl)
  );

  stbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .st_o        (st),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a beat");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  a_type_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.message_type <= stbc_pkg::TYPE_LOW_BATT))
    else $error("message type out of range");

endmodule

`default_nettype wire
